/* rtl/core/ps2kbf_pkg.sv */
// ---------------------------------------------------------------------------
// ps2kbf_pkg
// shared types and constants for the ps/2 keyboard receiver with key fifo
// ---------------------------------------------------------------------------
package ps2kbf_pkg;

   localparam int unsigned CODE_W     = 8;
   localparam int unsigned MAP_IDX_W  = 7;
   localparam int unsigned MAP_SIZE   = 128;
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned BITS_W     = 4;

   localparam logic [CODE_W-1:0] BREAK_PREFIX = 8'hF0;
   localparam logic [BITS_W-1:0] DATA_BITS    = 4'd8;

   // operation carried on req_tuser
   typedef enum logic [FUNC_W-1:0] {
      FUNC_EDGE      = 2'd0,
      FUNC_READ      = 2'd1,
      FUNC_MAP_WRITE = 2'd2
   } func_type;

   // position inside a ps/2 frame
   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_DATA   = 2'd1,
      PH_PARITY = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

endpackage

/* rtl/core/ps2_keyboard_receiver_fifo.sv */
// ---------------------------------------------------------------------------
// ps2_keyboard_receiver_fifo
// ps/2 device-to-host frame receiver feeding a fifo of translated key codes
// a read item passes the input register stage, then the response register
// throughput: one item per cycle while no read waits on a full response slot;
//   the single process stage updates frame state, keymap and fifo together
// reset: synchronous, active high; clears frame state, pointers and valids,
//   keymap and fifo contents are undefined until written
// ---------------------------------------------------------------------------
module ps2_keyboard_receiver_fifo #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_bit [0], map_index [7:1], map_value [15:8]
   input  logic [1:0]  req_tuser,   // func [1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // key_code [7:0]
   output logic        rsp_tuser    // empty_res
);
   import ps2kbf_pkg::*;

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_LAST) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // input register stage
   logic                 s1_valid_ff, s1_valid_in;
   func_type             s1_func_ff;
   logic                 s1_bit_ff;
   logic [MAP_IDX_W-1:0] s1_idx_ff;
   logic [CODE_W-1:0]    s1_val_ff;
   logic                 req_accept;
   logic                 s1_go;
   logic                 out_free;

   // frame and fifo state
   phase_type         phase_ff, phase_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              parity_ff, parity_in;
   logic [CODE_W-1:0] shift_ff, shift_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;

   // memories with registered read ports
   logic [CODE_W-1:0] keymap [MAP_SIZE];
   logic [CODE_W-1:0] queue  [FIFO_DEPTH];
   logic [CODE_W-1:0] km_rd_ff;    // keymap entry for the current shift byte
   logic [CODE_W-1:0] head_ff;     // queue entry at the read pointer
   logic              km_we;
   logic              q_we;
   logic [MAP_IDX_W-1:0] km_rd_addr;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic fifo_empty;
   logic parity_next;

   // handshake: the stage advances unless a read waits on a full response slot
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && ((s1_func_ff != FUNC_READ) || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff <= func_type'(req_tuser);
         s1_bit_ff  <= req_tdata[0];
         s1_idx_ff  <= req_tdata[7:1];
         s1_val_ff  <= req_tdata[15:8];
      end
   end

   assign fifo_empty  = (rd_ptr_ff == wr_ptr_ff);
   assign parity_next = parity_ff ^ s1_bit_ff;

   // process stage: frame decode, fifo push and pop, keymap write
   always_comb begin
      phase_in     = phase_ff;
      bits_in      = bits_ff;
      parity_in    = parity_ff;
      shift_in     = shift_ff;
      prev_in      = prev_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      km_we        = 1'b0;
      q_we         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_empty_in = rsp_empty_ff;

      if (s1_go) begin
         case (s1_func_ff)
            FUNC_EDGE: begin
               case (phase_ff)
                  PH_START: begin
                     // a high level at idle is not a start bit
                     if (!s1_bit_ff) begin
                        bits_in   = DATA_BITS;
                        parity_in = 1'b0;
                        phase_in  = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     shift_in  = {s1_bit_ff, shift_ff[CODE_W-1:1]};
                     parity_in = parity_next;
                     bits_in   = bits_ff - BITS_W'(1);
                     if (bits_in == '0) begin
                        phase_in = PH_PARITY;
                     end
                  end
                  PH_PARITY: begin
                     // odd parity over data and parity bit, else drop the frame
                     parity_in = parity_next;
                     phase_in  = parity_next ? PH_STOP : PH_START;
                  end
                  PH_STOP: begin
                     // good stop bit: code is done; break prefix and the code
                     // after it are not queued, and a full fifo drops the code
                     if (s1_bit_ff) begin
                        if ((shift_ff != BREAK_PREFIX) && (prev_ff != BREAK_PREFIX)
                            && (next_ptr(wr_ptr_ff) != rd_ptr_ff)) begin
                           q_we      = 1'b1;
                           wr_ptr_in = next_ptr(wr_ptr_ff);
                        end
                        prev_in = shift_ff;
                     end
                     phase_in = PH_START;
                  end
                  default: begin
                     phase_in = PH_START;
                  end
               endcase
            end
            FUNC_READ: begin
               rsp_valid_in = 1'b1;
               if (fifo_empty) begin
                  rsp_code_in  = '0;
                  rsp_empty_in = 1'b1;
               end else begin
                  rsp_code_in  = head_ff;
                  rsp_empty_in = 1'b0;
                  rd_ptr_in    = next_ptr(rd_ptr_ff);
               end
            end
            FUNC_MAP_WRITE: begin
               km_we = 1'b1;
            end
            default: begin
               // unused code, no effect
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         bits_ff      <= '0;
         parity_ff    <= 1'b0;
         shift_ff     <= '0;
         prev_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bits_ff      <= bits_in;
         parity_ff    <= parity_in;
         shift_ff     <= shift_in;
         prev_ff      <= prev_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff  <= rsp_code_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // keymap: read address follows the next shift byte so the entry is ready
   // at the stop bit; a write to that same entry is forwarded
   assign km_rd_addr = shift_in[MAP_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (km_we) begin
         keymap[s1_idx_ff] <= s1_val_ff;
      end
      if (km_we && (s1_idx_ff == km_rd_addr)) begin
         km_rd_ff <= s1_val_ff;
      end else begin
         km_rd_ff <= keymap[km_rd_addr];
      end
   end

   // code fifo: head register tracks the next read pointer, push forwarded
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue[wr_ptr_ff] <= km_rd_ff;
      end
      if (q_we && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= km_rd_ff;
      end else begin
         head_ff <= queue[rd_ptr_in];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // pointers never leave the fifo range
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (rd_ptr_ff <= PTR_LAST) && (wr_ptr_ff <= PTR_LAST))
      else $error("fifo pointer out of range");

   // data phase always has one to eight bits left
   a_bits_in_data: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> ((bits_ff != '0) && (bits_ff <= DATA_BITS)))
      else $error("bit counter out of range in data phase");

   // a read of an empty fifo leaves the read pointer alone
   a_empty_read_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_func_ff == FUNC_READ) && fifo_empty) |=> $stable(rd_ptr_ff))
      else $error("read pointer moved on empty read");

   // an empty response always carries code zero
   a_empty_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_code_ff == '0))
      else $error("empty response with nonzero code");

   // the fifo is never pushed while full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_we |-> (next_ptr(wr_ptr_ff) != rd_ptr_ff))
      else $error("push into full fifo");

endmodule

/* test/tb_ps2_keyboard_receiver_fifo.sv */
// ---------------------------------------------------------------------------
// tb_ps2_keyboard_receiver_fifo
// self-checking bench for the ps/2 receiver and its translated key fifo:
// a short table of edge, read and keymap items runs first, then mostly
// well-formed frames with random codes, mixed with faulty frames, line
// noise, reads and keymap writes. a shadow of the receiver predicts every
// read response, and both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_ps2_keyboard_receiver_fifo;
   import ps2kbf_pkg::*;

   localparam int unsigned FIFO_DEPTH   = 16;
   localparam int unsigned QUEUE_ROOM   = FIFO_DEPTH - 1;
   localparam int          RANDOM_ITEMS = 2000;
   localparam int          LONG_HOLD    = 300;
   localparam int          DRAIN_CYCLES = 20;

   // func code the block has no use for
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // how a generated frame is spoiled
   localparam int FRAME_GOOD       = 0;
   localparam int FRAME_BAD_PARITY = 1;
   localparam int FRAME_BAD_STOP   = 2;

   typedef struct packed {
      logic [CODE_W-1:0] key;
      logic              empty;
   } key_read_type;

   typedef struct {
      logic [FUNC_W-1:0]    func;
      logic                 line_bit;
      logic [MAP_IDX_W-1:0] idx;
      logic [CODE_W-1:0]    val;
      logic                 typed;     // expected response typed in the row
      logic [CODE_W-1:0]    key;
      logic                 empty;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;     // data_bit [0], map_index [7:1], map_value [15:8]
   logic [1:0]  req_tuser = '0;     // func [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // key_code [7:0]
   logic        rsp_tuser;          // empty_res

   // travels beside each item so the monitor knows about typed rows
   logic         req_typed = 1'b0;
   key_read_type req_typed_read = '0;

   // shadow of the receiver
   phase_type         rx_phase     = PH_START;
   logic [BITS_W-1:0] rx_bits_left = '0;
   logic              rx_parity    = 1'b0;
   logic [CODE_W-1:0] rx_shift     = '0;
   logic [CODE_W-1:0] rx_prev_code = '0;
   logic [CODE_W-1:0] shadow_keymap [MAP_SIZE];
   logic [CODE_W-1:0] shadow_fifo [$];
   key_read_type      due_key_reads [$];

   int mismatch_count = 0;
   int sent_items     = 0;
   bit req_calm       = 1'b0;
   bit rsp_calm       = 1'b0;
   bit hold_responses = 1'b0;

   ps2_keyboard_receiver_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far above the slowest correct run
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // advance the shadow by one accepted item, queue the response of a read
   task automatic shadow_keyboard(input logic [FUNC_W-1:0] f, input logic [15:0] d,
                                  input logic typed, input key_read_type typed_read);
      key_read_type got;
      case (f)
         FUNC_EDGE: begin
            case (rx_phase)
               PH_START: begin
                  // a high line at idle is not a start bit
                  if (!d[0]) begin
                     rx_bits_left = DATA_BITS;
                     rx_parity    = 1'b0;
                     rx_phase     = PH_DATA;
                  end
               end
               PH_DATA: begin
                  // lsb first, so each bit enters at the top
                  rx_shift     = {d[0], rx_shift[CODE_W-1:1]};
                  rx_parity    = rx_parity ^ d[0];
                  rx_bits_left = rx_bits_left - 1'b1;
                  if (rx_bits_left == '0) rx_phase = PH_PARITY;
               end
               PH_PARITY: begin
                  // even total parity drops the frame
                  rx_parity = rx_parity ^ d[0];
                  rx_phase  = rx_parity ? PH_STOP : PH_START;
               end
               default: begin
                  // low stop bit drops the frame and keeps the last code
                  if (d[0]) begin
                     if (rx_shift != BREAK_PREFIX && rx_prev_code != BREAK_PREFIX
                         && shadow_fifo.size() < QUEUE_ROOM)
                        shadow_fifo.push_back(shadow_keymap[rx_shift[MAP_IDX_W-1:0]]);
                     rx_prev_code = rx_shift;
                  end
                  rx_phase = PH_START;
               end
            endcase
         end
         FUNC_READ: begin
            if (shadow_fifo.size() == 0) begin
               got.key   = '0;
               got.empty = 1'b1;
            end else begin
               got.key   = shadow_fifo.pop_front();
               got.empty = 1'b0;
            end
            due_key_reads.push_back(typed ? typed_read : got);
         end
         FUNC_MAP_WRITE: shadow_keymap[d[7:1]] = d[15:8];
         default: ;
      endcase
   endtask

   task automatic check_key_read();
      key_read_type want;
      if (due_key_reads.size() == 0) begin
         flag_mismatch($sformatf("response %02h/%0b with none pending", rsp_tdata, rsp_tuser));
      end else begin
         want = due_key_reads.pop_front();
         if (rsp_tdata !== want.key)
            flag_mismatch($sformatf("key_code %02h, expected %02h", rsp_tdata, want.key));
         if (rsp_tuser !== want.empty)
            flag_mismatch($sformatf("empty_res %0b, expected %0b", rsp_tuser, want.empty));
      end
   endtask

   // monitor: check before predicting, a read never answers on its own edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_key_read();
         if (req_tvalid && req_tready)
            shadow_keyboard(req_tuser, req_tdata, req_typed, req_typed_read);
      end
   end

   // one item on the request side, returns at the edge that takes it
   task automatic push_item(input logic [FUNC_W-1:0] f, input logic line_bit,
                            input logic [MAP_IDX_W-1:0] idx, input logic [CODE_W-1:0] val,
                            input logic typed, input key_read_type typed_read);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid     <= 1'b1;
      req_tuser      <= f;
      req_tdata      <= {val, idx, line_bit};
      req_typed      <= typed;
      req_typed_read <= typed_read;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (f != FUNC_UNUSED) sent_items++;
   endtask

   // unused fields carry junk so every input bit toggles
   task automatic edge_item(input logic line_bit);
      push_item(FUNC_EDGE, line_bit, 7'($urandom), 8'($urandom), 1'b0, '0);
   endtask

   task automatic read_item();
      push_item(FUNC_READ, 1'($urandom), 7'($urandom), 8'($urandom), 1'b0, '0);
   endtask

   // start, eight data bits lsb first, odd parity, stop
   task automatic send_frame(input logic [CODE_W-1:0] code, input int fault);
      logic parity_bit;
      int   dice;
      parity_bit = ~(^code);
      if (fault == FRAME_BAD_PARITY) parity_bit = ~parity_bit;
      edge_item(1'b0);
      for (int i = 0; i < CODE_W; i++) begin
         // reads and keymap writes may fall in the middle of a frame
         dice = $urandom_range(0, 99);
         if (dice < 4)
            read_item();
         else if (dice < 6)
            push_item(FUNC_MAP_WRITE, 1'($urandom), 7'($urandom), 8'($urandom), 1'b0, '0);
         edge_item(code[i]);
      end
      edge_item(parity_bit);
      edge_item(fault != FRAME_BAD_STOP);
   endtask

   // sender pause: lower valid, then wait until every read has answered
   task automatic settle_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_key_reads.size() != 0);
   endtask

   // response side: random stall per item, calm stretches, one long hold
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_calm = !rsp_calm;
         if (hold_responses) begin
            hold_responses = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = rsp_calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // stimulus
   initial begin
      stim_row_type      dir_rows [$];
      stim_row_type      row;
      logic [CODE_W-1:0] code;
      int                pick;
      int                fault;
      int                base;
      bit                paused;

      paused = 1'b0;

      // directed table
      // read after reset finds nothing queued
      dir_rows.push_back('{FUNC_READ, 1'b1, 7'h7F, 8'hFF, 1'b1, 8'h00, 1'b1});
      // keymap extremes
      dir_rows.push_back('{FUNC_MAP_WRITE, 1'b1, 7'h7F, 8'hFF, 1'b0, 8'h00, 1'b0});
      dir_rows.push_back('{FUNC_MAP_WRITE, 1'b0, 7'h00, 8'h00, 1'b0, 8'h00, 1'b0});
      // unused func is ignored
      dir_rows.push_back('{FUNC_UNUSED, 1'b1, 7'h7F, 8'hFF, 1'b0, 8'h00, 1'b0});
      // high line at idle is not a start bit
      dir_rows.push_back('{FUNC_EDGE, 1'b1, 7'h00, 8'h00, 1'b0, 8'h00, 1'b0});
      // frame with code ff: start, eight ones, parity one, stop
      dir_rows.push_back('{FUNC_EDGE, 1'b0, 7'h00, 8'h00, 1'b0, 8'h00, 1'b0});
      for (int i = 0; i < 10; i++)
         dir_rows.push_back('{FUNC_EDGE, 1'b1, 7'h55, 8'hAA, 1'b0, 8'h00, 1'b0});
      // code ff maps through entry 7f
      dir_rows.push_back('{FUNC_READ, 1'b0, 7'h00, 8'h00, 1'b1, 8'hFF, 1'b0});
      dir_rows.push_back('{FUNC_READ, 1'b0, 7'h00, 8'h00, 1'b1, 8'h00, 1'b1});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         push_item(row.func, row.line_bit, row.idx, row.val, row.typed, '{row.key, row.empty});
      end

      // fill the whole keymap so any received code reads a written entry
      for (int i = 0; i < MAP_SIZE; i++)
         push_item(FUNC_MAP_WRITE, 1'($urandom), 7'(i), 8'($urandom), 1'b0, '0);

      // overfill the fifo, then read it out while the response side holds off
      for (int i = 0; i < QUEUE_ROOM + 4; i++)
         send_frame(8'($urandom_range(0, 8'hEF)), FRAME_GOOD);
      hold_responses = 1'b1;
      repeat (QUEUE_ROOM + 6) read_item();
      settle_responses();

      // random part
      base = sent_items;
      while (sent_items < base + RANDOM_ITEMS) begin
         if ($urandom_range(0, 199) == 0) req_calm = !req_calm;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // well-formed frames mostly, break prefix often
            code  = ($urandom_range(0, 4) == 0) ? BREAK_PREFIX : 8'($urandom);
            pick  = $urandom_range(0, 9);
            fault = (pick == 0) ? FRAME_BAD_PARITY :
                    (pick == 1) ? FRAME_BAD_STOP : FRAME_GOOD;
            send_frame(code, fault);
         end else if (pick < 75) begin
            read_item();
         end else if (pick < 85) begin
            push_item(FUNC_MAP_WRITE, 1'($urandom), 7'($urandom), 8'($urandom), 1'b0, '0);
         end else if (pick < 89) begin
            push_item(FUNC_UNUSED, 1'($urandom), 7'($urandom), 8'($urandom), 1'b0, '0);
         end else if (pick < 95) begin
            // line noise, sometimes followed by enough high bits to resync
            repeat ($urandom_range(1, 4)) edge_item(1'($urandom));
            if ($urandom_range(0, 1) == 1) repeat (11) edge_item(1'b1);
         end else begin
            // burst of good codes to push the fifo towards full
            repeat ($urandom_range(3, 8))
               send_frame(8'($urandom_range(0, 8'hEF)), FRAME_GOOD);
         end
         if (!paused && sent_items >= base + RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            settle_responses();
         end
      end

      settle_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
